FILE: rtl/rmq_pkg.sv
// Shared types and constants for the rotation matrix to quaternion pipeline.
// No dependencies.
package rmq_pkg;

    // Selected decomposition case
    typedef enum logic [1:0] {
        CASE_TRACE = 2'd0,
        CASE_X     = 2'd1,
        CASE_Y     = 2'd2,
        CASE_Z     = 2'd3
    } case_t;

    localparam int FIELD_W = 16;                     // matrix element / component width
    localparam int MAG_W   = 17;                     // |numerator| width
    localparam int QB      = 16;                     // quotient bits before saturation
    localparam int SSW     = 2 + 1 + 3 + 3 * MAG_W;  // side payload through root cells
    localparam int DSW     = 2 + 1 + 3 + FIELD_W;    // side payload through divide cells

    localparam logic [FIELD_W-1:0] SAT_POS = 16'h7FFF;
    localparam logic [FIELD_W-1:0] SAT_NEG = 16'h8000;

endpackage

FILE: rtl/rmq_sqrt_cell.sv
// One stage of the pipelined integer square root: one root bit per cell.
// Depends on rmq_pkg.
module rmq_sqrt_cell #(
    parameter int NW = 32,
    parameter int TW = 16
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     en,
    input  logic                     valid_i,
    input  logic [TW+2:0]            rem_i,
    input  logic [TW-1:0]            root_i,
    input  logic [NW-1:0]            n_i,
    input  logic [rmq_pkg::SSW-1:0]  side_i,
    output logic                     valid_o,
    output logic [TW+2:0]            rem_o,
    output logic [TW-1:0]            root_o,
    output logic [NW-1:0]            n_o,
    output logic [rmq_pkg::SSW-1:0]  side_o
);

    logic          valid_reg;
    logic [TW+2:0] rem_reg, rem_next, r2, trial;
    logic [TW-1:0] root_reg, root_next;
    logic [NW-1:0] n_reg;
    logic [rmq_pkg::SSW-1:0] side_reg;
    logic          ge;

    always_comb begin
        // bring down the next two radicand bits
        r2        = {rem_i[TW:0], n_i[NW-1:NW-2]};
        trial     = {1'b0, root_i, 2'b01};
        ge        = r2 >= trial;
        rem_next  = ge ? (r2 - trial) : r2;
        root_next = {root_i[TW-2:0], ge};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= valid_i;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg  <= rem_next;
            root_reg <= root_next;
            n_reg    <= {n_i[NW-3:0], 2'b00};
            side_reg <= side_i;
        end
    end

    assign valid_o = valid_reg;
    assign rem_o   = rem_reg;
    assign root_o  = root_reg;
    assign n_o     = n_reg;
    assign side_o  = side_reg;

endmodule

FILE: rtl/rmq_div_cell.sv
// One stage of the three-lane restoring divider: one quotient bit per lane.
// Depends on rmq_pkg.
module rmq_div_cell #(
    parameter int DVW = 17,
    parameter int PRW = 18
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         en,
    input  logic                         valid_i,
    input  logic [DVW-1:0]               d_i,
    input  logic [PRW-1:0]               pr_i  [3],
    input  logic [rmq_pkg::QB-1:0]       nl_i  [3],
    input  logic [rmq_pkg::QB-1:0]       q_i   [3],
    input  logic [2:0]                   ovf_i,
    input  logic [rmq_pkg::DSW-1:0]      side_i,
    output logic                         valid_o,
    output logic [DVW-1:0]               d_o,
    output logic [PRW-1:0]               pr_o  [3],
    output logic [rmq_pkg::QB-1:0]       nl_o  [3],
    output logic [rmq_pkg::QB-1:0]       q_o   [3],
    output logic [2:0]                   ovf_o,
    output logic [rmq_pkg::DSW-1:0]      side_o
);

    logic                    valid_reg;
    logic [DVW-1:0]          d_reg;
    logic [PRW-1:0]          pr_reg [3];
    logic [PRW-1:0]          pr_next [3];
    logic [rmq_pkg::QB-1:0]  nl_reg [3];
    logic [rmq_pkg::QB-1:0]  q_reg [3];
    logic [rmq_pkg::QB-1:0]  q_next [3];
    logic [2:0]              ovf_reg;
    logic [rmq_pkg::DSW-1:0] side_reg;

    always_comb begin
        logic [PRW-1:0] p2;
        logic           ge;
        for (int l = 0; l < 3; l++) begin
            p2         = {pr_i[l][PRW-2:0], nl_i[l][rmq_pkg::QB-1]};
            ge         = p2 >= PRW'(d_i);
            pr_next[l] = ge ? (p2 - PRW'(d_i)) : p2;
            q_next[l]  = {q_i[l][rmq_pkg::QB-2:0], ge};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= valid_i;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d_reg    <= d_i;
            ovf_reg  <= ovf_i;
            side_reg <= side_i;
            for (int l = 0; l < 3; l++) begin
                pr_reg[l] <= pr_next[l];
                q_reg[l]  <= q_next[l];
                nl_reg[l] <= {nl_i[l][rmq_pkg::QB-2:0], 1'b0};
            end
        end
    end

    assign valid_o = valid_reg;
    assign d_o     = d_reg;
    assign pr_o    = pr_reg;
    assign nl_o    = nl_reg;
    assign q_o     = q_reg;
    assign ovf_o   = ovf_reg;
    assign side_o  = side_reg;

endmodule

FILE: rtl/rotation_matrix_to_quaternion.sv
// Rotation matrix to unit quaternion converter, top level.
// Depends on rmq_pkg, rmq_sqrt_cell and rmq_div_cell.
//
// Usage:
//   s_ channel: one beat carries the nine matrix elements, signed Q2.FRAC_BITS.
//   m_ channel: one beat per input beat with the quaternion in tdata and the
//   selected case plus the invalid flag in tuser.
// Pipeline order: front register, square-root chain of TW root cells, where
//   TW = ceil((max(FRAC_BITS,17) + 1 + FRAC_BITS) / 2) (one root bit per
//   cell), then the divider set-up register, the 16-cell divider chain and
//   the output register.
// Throughput: one beat per cycle while s_tready is high; else cells hold.
// Stalls: the output register is backed by a one-beat skid buffer. While the
//   receiver stalls, the chain keeps moving until the skid buffer fills; then
//   s_tready drops and the whole chain holds.
// Reset: aresetn clears all valid flags; the pipeline comes up empty.
// Invalid input (non-positive radicand): quaternion is zero, invalid is set,
//   case_used still reports the selected case.
module rotation_matrix_to_quaternion #(
    parameter int FRAC_BITS = 14
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // m_xx, m_xy, m_xz, m_yx, m_yy, m_yz, m_zx, m_zy, m_zz (16 bits each)
    input  logic [143:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // quat_real, quat_i, quat_j, quat_k (16 bits each)
    output logic [63:0]  m_tdata,
    // case_used [1:0], invalid [2]
    output logic [2:0]   m_tuser
);

    localparam int RW   = ((FRAC_BITS > 17) ? FRAC_BITS : 17) + 1;
    localparam int TW   = (RW + FRAC_BITS + 1) / 2;
    localparam int NW   = 2 * TW;
    localparam int NUMW = rmq_pkg::MAG_W + FRAC_BITS + 1;
    localparam int DVW  = TW + 1;
    localparam int PRW  = TW + 2;
    localparam int HIW  = NUMW - rmq_pkg::QB;
    localparam int CMPW = (HIW > DVW) ? HIW : DVW;
    localparam int QB   = rmq_pkg::QB;

    logic en;

    // ---------------- front stage: case select, radicand, numerators
    logic signed [15:0] xx, xy, xz, yx, yy, yz, zx, zy, zz;
    logic signed [17:0] tr;
    logic signed [RW:0] rad, one_s;
    rmq_pkg::case_t     sel;
    logic signed [16:0] num [3];
    logic [rmq_pkg::SSW-1:0] f_side;

    always_comb begin
        xx = s_tdata[15:0];    xy = s_tdata[31:16];   xz = s_tdata[47:32];
        yx = s_tdata[63:48];   yy = s_tdata[79:64];   yz = s_tdata[95:80];
        zx = s_tdata[111:96];  zy = s_tdata[127:112]; zz = s_tdata[143:128];
        tr    = 18'(xx) + 18'(yy) + 18'(zz);
        one_s = (RW+1)'(1) << FRAC_BITS;
        if (tr > 18'sd0) begin
            sel    = rmq_pkg::CASE_TRACE;
            rad    = one_s + (RW+1)'(tr);
            num[0] = 17'(yz) - 17'(zy);
            num[1] = 17'(zx) - 17'(xz);
            num[2] = 17'(xy) - 17'(yx);
        end else if (xx > yy && xx > zz) begin
            sel    = rmq_pkg::CASE_X;
            rad    = one_s + (RW+1)'(xx) - (RW+1)'(yy) - (RW+1)'(zz);
            num[0] = 17'(yz) - 17'(zy);
            num[1] = 17'(yx) + 17'(xy);
            num[2] = 17'(zx) + 17'(xz);
        end else if (yy > zz) begin
            sel    = rmq_pkg::CASE_Y;
            rad    = one_s + (RW+1)'(yy) - (RW+1)'(xx) - (RW+1)'(zz);
            num[0] = 17'(zx) - 17'(xz);
            num[1] = 17'(yx) + 17'(xy);
            num[2] = 17'(zy) + 17'(yz);
        end else begin
            sel    = rmq_pkg::CASE_Z;
            rad    = one_s + (RW+1)'(zz) - (RW+1)'(xx) - (RW+1)'(yy);
            num[0] = 17'(xy) - 17'(yx);
            num[1] = 17'(zx) + 17'(xz);
            num[2] = 17'(zy) + 17'(yz);
        end
        f_side[1:0] = sel;
        f_side[2]   = rad[RW] || (rad == '0);
        for (int l = 0; l < 3; l++) begin
            f_side[3+l] = num[l][16];
            f_side[6 + l*rmq_pkg::MAG_W +: rmq_pkg::MAG_W] =
                num[l][16] ? 17'(-num[l]) : 17'(num[l]);
        end
    end

    logic                    f_valid_reg;
    logic [rmq_pkg::SSW-1:0] f_side_reg;
    logic [NW-1:0]           f_n_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f_valid_reg <= 1'b0;
        end else if (en) begin
            f_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            f_side_reg <= f_side;
            f_n_reg    <= NW'(rad[RW-1:0]) << FRAC_BITS;
        end
    end

    // ---------------- square-root chain
    logic                    sq_v    [TW+1];
    logic [TW+2:0]           sq_rem  [TW+1];
    logic [TW-1:0]           sq_root [TW+1];
    logic [NW-1:0]           sq_n    [TW+1];
    logic [rmq_pkg::SSW-1:0] sq_side [TW+1];

    assign sq_v[0]    = f_valid_reg;
    assign sq_rem[0]  = '0;
    assign sq_root[0] = '0;
    assign sq_n[0]    = f_n_reg;
    assign sq_side[0] = f_side_reg;

    for (genvar g = 0; g < TW; g++) begin : g_sqrt
        rmq_sqrt_cell #(.NW(NW), .TW(TW)) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (en),
            .valid_i (sq_v[g]),
            .rem_i   (sq_rem[g]),
            .root_i  (sq_root[g]),
            .n_i     (sq_n[g]),
            .side_i  (sq_side[g]),
            .valid_o (sq_v[g+1]),
            .rem_o   (sq_rem[g+1]),
            .root_o  (sq_root[g+1]),
            .n_o     (sq_n[g+1]),
            .side_o  (sq_side[g+1])
        );
    end

    // ---------------- divider set-up: numerators, divisor, overflow check
    logic [TW-1:0]           t_root;
    logic [TW:0]             sc_wide;
    logic [DVW-1:0]          p_d;
    logic [PRW-1:0]          p_pr  [3];
    logic [QB-1:0]           p_nl  [3];
    logic [2:0]              p_ovf;
    logic [rmq_pkg::DSW-1:0] p_side;

    always_comb begin
        logic [NUMW-1:0]         numer;
        logic [rmq_pkg::MAG_W-1:0] mag;
        t_root  = sq_root[TW];
        p_d     = {t_root, 1'b0};
        sc_wide = ((TW+1)'(t_root) + (TW+1)'(1)) >> 1;
        for (int l = 0; l < 3; l++) begin
            mag      = sq_side[TW][6 + l*rmq_pkg::MAG_W +: rmq_pkg::MAG_W];
            numer    = (NUMW'(mag) << FRAC_BITS) + NUMW'(t_root);
            p_ovf[l] = CMPW'(numer[NUMW-1:QB]) >= CMPW'(p_d);
            p_pr[l]  = PRW'(numer[NUMW-1:QB]);
            p_nl[l]  = numer[QB-1:0];
        end
        p_side[5:0] = sq_side[TW][5:0];
        p_side[rmq_pkg::DSW-1:6] = (sc_wide > (TW+1)'(32767)) ? rmq_pkg::SAT_POS
                                                              : 16'(sc_wide);
    end

    logic                    p_valid_reg;
    logic [DVW-1:0]          p_d_reg;
    logic [PRW-1:0]          p_pr_reg [3];
    logic [QB-1:0]           p_nl_reg [3];
    logic [2:0]              p_ovf_reg;
    logic [rmq_pkg::DSW-1:0] p_side_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_valid_reg <= 1'b0;
        end else if (en) begin
            p_valid_reg <= sq_v[TW];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p_d_reg    <= p_d;
            p_pr_reg   <= p_pr;
            p_nl_reg   <= p_nl;
            p_ovf_reg  <= p_ovf;
            p_side_reg <= p_side;
        end
    end

    // ---------------- divider chain
    logic                    dv_v    [QB+1];
    logic [DVW-1:0]          dv_d    [QB+1];
    logic [PRW-1:0]          dv_pr   [QB+1][3];
    logic [QB-1:0]           dv_nl   [QB+1][3];
    logic [QB-1:0]           dv_q    [QB+1][3];
    logic [2:0]              dv_ovf  [QB+1];
    logic [rmq_pkg::DSW-1:0] dv_side [QB+1];

    assign dv_v[0]    = p_valid_reg;
    assign dv_d[0]    = p_d_reg;
    assign dv_pr[0]   = p_pr_reg;
    assign dv_nl[0]   = p_nl_reg;
    assign dv_q[0]    = '{default: '0};
    assign dv_ovf[0]  = p_ovf_reg;
    assign dv_side[0] = p_side_reg;

    for (genvar g = 0; g < QB; g++) begin : g_div
        rmq_div_cell #(.DVW(DVW), .PRW(PRW)) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (en),
            .valid_i (dv_v[g]),
            .d_i     (dv_d[g]),
            .pr_i    (dv_pr[g]),
            .nl_i    (dv_nl[g]),
            .q_i     (dv_q[g]),
            .ovf_i   (dv_ovf[g]),
            .side_i  (dv_side[g]),
            .valid_o (dv_v[g+1]),
            .d_o     (dv_d[g+1]),
            .pr_o    (dv_pr[g+1]),
            .nl_o    (dv_nl[g+1]),
            .q_o     (dv_q[g+1]),
            .ovf_o   (dv_ovf[g+1]),
            .side_o  (dv_side[g+1])
        );
    end

    // ---------------- result assembly with saturation
    logic [15:0]    lane_val [3];
    logic [15:0]    sc16;
    logic [63:0]    h_data;
    logic [2:0]     h_user;
    rmq_pkg::case_t h_sel;
    logic           h_inv;

    always_comb begin
        logic [2:0] sgn;
        sgn   = dv_side[QB][5:3];
        h_sel = rmq_pkg::case_t'(dv_side[QB][1:0]);
        h_inv = dv_side[QB][2];
        sc16  = dv_side[QB][rmq_pkg::DSW-1:6];
        for (int l = 0; l < 3; l++) begin
            if (!sgn[l]) begin
                lane_val[l] = (dv_ovf[QB][l] || dv_q[QB][l] > 16'd32767)
                              ? rmq_pkg::SAT_POS : dv_q[QB][l];
            end else begin
                lane_val[l] = (dv_ovf[QB][l] || dv_q[QB][l] > 16'd32768)
                              ? rmq_pkg::SAT_NEG : 16'(-dv_q[QB][l]);
            end
        end
        unique case (h_sel)
            rmq_pkg::CASE_TRACE: h_data = {lane_val[2], lane_val[1], lane_val[0], sc16};
            rmq_pkg::CASE_X:     h_data = {lane_val[2], lane_val[1], sc16, lane_val[0]};
            rmq_pkg::CASE_Y:     h_data = {lane_val[2], sc16, lane_val[1], lane_val[0]};
            default:             h_data = {sc16, lane_val[2], lane_val[1], lane_val[0]};
        endcase
        if (h_inv) begin
            h_data = '0;
        end
        h_user = {h_inv, h_sel};
    end

    // ---------------- output register and skid buffer
    logic        m_valid_reg, skid_valid_reg;
    logic [63:0] m_data_reg, skid_data_reg;
    logic [2:0]  m_user_reg, skid_user_reg;
    logic        out_free, head_take;

    assign en        = !skid_valid_reg;
    assign out_free  = !m_valid_reg || m_tready;
    assign head_take = dv_v[QB] && en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (out_free) begin
            if (skid_valid_reg) begin
                m_valid_reg    <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                m_valid_reg    <= head_take;
            end
        end else if (head_take) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free) begin
            if (skid_valid_reg) begin
                m_data_reg <= skid_data_reg;
                m_user_reg <= skid_user_reg;
            end else begin
                m_data_reg <= h_data;
                m_user_reg <= h_user;
            end
        end else if (head_take) begin
            skid_data_reg <= h_data;
            skid_user_reg <= h_user;
        end
    end

    assign s_tready = en;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

`ifndef SYNTHESIS
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> m_valid_reg)
        else $error("skid buffer holds a beat while output register is empty");

    a_invalid_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_user_reg[2]) |-> (m_data_reg == '0))
        else $error("invalid result carries non-zero quaternion");

    a_stall_to_skid: assert property (@(posedge aclk) disable iff (!aresetn)
        (head_take && !out_free) |=> skid_valid_reg)
        else $error("beat from the chain lost during output stall");
`endif

endmodule

FILE: tb/tb.sv
// Self-checking testbench for rotation_matrix_to_quaternion.
// Directed table then random matrices, each checked against table values or a built-in quaternion predictor.
// Depends on rmq_pkg and the rotation_matrix_to_quaternion RTL.
`timescale 1ns / 100ps

module tb;

    localparam int FRAC      = 14;
    localparam int N_RANDOM  = 850;
    localparam int IDLE_LIM  = 5000;
    localparam int DRAIN_CYC = 80;

    typedef struct packed {
        logic [15:0]    qk;
        logic [15:0]    qj;
        logic [15:0]    qi;
        logic [15:0]    qr;
        rmq_pkg::case_t sel;
        logic           bad;
    } quat_t;

    typedef struct {
        logic [143:0] mat;
        logic         known;
        quat_t        q;
    } row_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [143:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [63:0]  m_tdata;
    logic [2:0]   m_tuser;

    quat_t quat_q[$];
    int    errors = 0;
    int    idle_cycles = 0;
    bit    calm = 1'b0;
    row_t  table_rows[$];

    rotation_matrix_to_quaternion #(.FRAC_BITS(FRAC)) u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    function automatic longint elem(logic [143:0] m, int idx);
        return longint'($signed(m[idx*16 +: 16]));
    endfunction

    function automatic longint root_floor(longint n);
        longint r;
        r = 0;
        for (int b = 31; b >= 0; b--)
            if ((r + (longint'(1) << b)) * (r + (longint'(1) << b)) <= n)
                r = r + (longint'(1) << b);
        return r;
    endfunction

    function automatic longint div_round(longint d, longint t);
        longint mag;
        longint q;
        mag = (d < 0) ? -d : d;
        q = ((mag << FRAC) + t) / (2 * t);
        return (d < 0) ? -q : q;
    endfunction

    function automatic logic [15:0] clip16(longint v);
        if (v > 32767) return 16'h7FFF;
        if (v < -32768) return 16'h8000;
        return v[15:0];
    endfunction

    function automatic quat_t predict_quat(logic [143:0] m);
        longint xx, xy, xz, yx, yy, yz, zx, zy, zz, tr, rad, t;
        longint c[4];
        quat_t q;
        xx = elem(m, 0); xy = elem(m, 1); xz = elem(m, 2);
        yx = elem(m, 3); yy = elem(m, 4); yz = elem(m, 5);
        zx = elem(m, 6); zy = elem(m, 7); zz = elem(m, 8);
        tr = xx + yy + zz;
        q = '0;
        if (tr > 0) begin
            q.sel = rmq_pkg::CASE_TRACE; rad = tr;
        end else if (xx > yy && xx > zz) begin
            q.sel = rmq_pkg::CASE_X; rad = xx - yy - zz;
        end else if (yy > zz) begin
            q.sel = rmq_pkg::CASE_Y; rad = yy - xx - zz;
        end else begin
            q.sel = rmq_pkg::CASE_Z; rad = zz - xx - yy;
        end
        rad = rad + (longint'(1) << FRAC);
        if (rad <= 0) begin
            q.bad = 1'b1;
            return q;
        end
        t = root_floor(rad << FRAC);
        case (q.sel)
            rmq_pkg::CASE_TRACE: begin
                c[1] = div_round(yz - zy, t); c[2] = div_round(zx - xz, t);
                c[3] = div_round(xy - yx, t);
            end
            rmq_pkg::CASE_X: begin
                c[0] = div_round(yz - zy, t); c[2] = div_round(yx + xy, t);
                c[3] = div_round(zx + xz, t);
            end
            rmq_pkg::CASE_Y: begin
                c[0] = div_round(zx - xz, t); c[1] = div_round(yx + xy, t);
                c[3] = div_round(zy + yz, t);
            end
            default: begin
                c[0] = div_round(xy - yx, t); c[1] = div_round(zx + xz, t);
                c[2] = div_round(zy + yz, t);
            end
        endcase
        c[int'(q.sel)] = (t + 1) >>> 1;
        q.qr = clip16(c[0]); q.qi = clip16(c[1]);
        q.qj = clip16(c[2]); q.qk = clip16(c[3]);
        return q;
    endfunction

    function automatic logic [143:0] pack_mat(int v[9]);
        logic [143:0] m;
        for (int i = 0; i < 9; i++) m[i*16 +: 16] = 16'(v[i]);
        return m;
    endfunction

    function automatic int rnd_elem();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) return $urandom_range(0, 65535) - 32768;
        if (r == 1) return (r == 1 && $urandom_range(0, 1)) ? 16384 : -16384;
        return $urandom_range(0, 32768) - 16384;
    endfunction

    // mostly near a rotation (identity-like or one dominant diagonal, with small perturbations), else random
    function automatic logic [143:0] rnd_matrix();
        int v[9];
        int mode;
        mode = $urandom_range(0, 9);
        for (int i = 0; i < 9; i++) v[i] = rnd_elem();
        if (mode < 6) begin
            for (int i = 0; i < 9; i++) v[i] = v[i] / 4;
            case ($urandom_range(0, 3))
                0: begin v[0] = 14000; v[4] = 12000; v[8] = 13000; end
                1: begin v[0] = 15000; v[4] = -9000; v[8] = -8000; end
                2: begin v[0] = -9000; v[4] = 15000; v[8] = -8000; end
                default: begin v[0] = -8000; v[4] = -9000; v[8] = 15000; end
            endcase
            v[0] += $urandom_range(0, 2000) - 1000;
            v[4] += $urandom_range(0, 2000) - 1000;
            v[8] += $urandom_range(0, 2000) - 1000;
        end
        return pack_mat(v);
    endfunction

    task automatic send_beat(logic [143:0] m);
        while (!calm && $urandom_range(0, 99) < 22) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= m;
        quat_q.push_back(predict_quat(m));
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic add_row(int v[9], logic known, quat_t q);
        row_t r;
        r.mat = pack_mat(v); r.known = known; r.q = q;
        table_rows.push_back(r);
    endtask

    // receiver stall pattern
    always @(posedge aclk) begin
        if (!aresetn) m_tready <= 1'b0;
        else m_tready <= calm || ($urandom_range(0, 99) >= 22);
    end

    always @(posedge aclk) begin
        quat_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = {m_tdata, rmq_pkg::case_t'(m_tuser[1:0]), m_tuser[2]};
            if (quat_q.size() == 0) begin
                $display("%0t: result beat with none expected: %h", $time, got);
                errors++;
            end else begin
                want = quat_q.pop_front();
                if (got.qr !== want.qr || got.qi !== want.qi || got.qj !== want.qj ||
                    got.qk !== want.qk || got.sel !== want.sel || got.bad !== want.bad) begin
                    $display("%0t: mismatch expected r=%h i=%h j=%h k=%h case=%0d inv=%b",
                             $time, want.qr, want.qi, want.qj, want.qk, want.sel, want.bad);
                    $display("%0t:          actual r=%h i=%h j=%h k=%h case=%0d inv=%b",
                             $time, got.qr, got.qi, got.qj, got.qk, got.sel, got.bad);
                    errors++;
                end
            end
        end
    end

    // watchdog on cycles with no beat on either side
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIM) begin
            $display("rotation_matrix_to_quaternion regression: fail");
            $finish;
        end
    end

    initial begin
        quat_t q;
        int    drain;
        q = '0;
        // identity and its half-turns: exact unit components
        q.sel = rmq_pkg::CASE_TRACE; q.qr = 16'd16384;
        add_row('{16384, 0, 0, 0, 16384, 0, 0, 0, 16384}, 1'b1, q);
        q = '0; q.sel = rmq_pkg::CASE_X; q.qi = 16'd16384;
        add_row('{16384, 0, 0, 0, -16384, 0, 0, 0, -16384}, 1'b1, q);
        q = '0; q.sel = rmq_pkg::CASE_Y; q.qj = 16'd16384;
        add_row('{-16384, 0, 0, 0, 16384, 0, 0, 0, -16384}, 1'b1, q);
        q = '0; q.sel = rmq_pkg::CASE_Z; q.qk = 16'd16384;
        add_row('{-16384, 0, 0, 0, -16384, 0, 0, 0, 16384}, 1'b1, q);
        // all-zero matrix: z case, radicand is just one, root component one half
        q = '0; q.sel = rmq_pkg::CASE_Z; q.qk = 16'd8192;
        add_row('{0, 0, 0, 0, 0, 0, 0, 0, 0}, 1'b1, q);
        // deep negative diagonals
        add_row('{-32768, 32767, 32767, 32767, -32768, 32767, 32767, 32767, 0},
                1'b0, q);
        q = '0; q.sel = rmq_pkg::CASE_X; q.bad = 1'b1;
        add_row('{-16384, 0, 0, 0, -16385, 5, 0, 0, -16385}, 1'b0, q);
        // extremes of every field, then assorted small matrices
        add_row('{-16383, 32767, -32768, -32768, -16384, 32767, 32767, -32768, -16384},
                1'b0, q);
        add_row('{32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767}, 1'b0, q);
        add_row('{-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768},
                1'b0, q);
        add_row('{-1, -1, -1, -1, -1, -1, -1, -1, -1}, 1'b0, q);
        add_row('{1, 0, 0, 0, 1, 0, 0, 0, -2}, 1'b0, q);
        add_row('{0, 11585, 0, -11585, 0, 0, 0, 0, 16384}, 1'b0, q);
        add_row('{0, -16384, 0, 16384, 0, 0, 0, 0, 0}, 1'b0, q);
        add_row('{-100, 300, 200, 300, -100, 400, 200, 400, -100}, 1'b0, q);
        add_row('{-100, 300, 200, 300, 50, 400, 200, 400, -100}, 1'b0, q);
        add_row('{5, 1, 2, 3, 5, 4, 6, 7, -10}, 1'b0, q);

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (table_rows[n]) begin
            q = table_rows[n].known ? table_rows[n].q : predict_quat(table_rows[n].mat);
            if (table_rows[n].known && q !== predict_quat(table_rows[n].mat))
                $display("%0t: table row %0d disagrees with predictor", $time, n);
            send_beat(table_rows[n].mat);
            void'(quat_q.pop_back());
            quat_q.push_back(q);
        end

        for (int n = 0; n < N_RANDOM; n++) begin
            calm = (n >= 400 && n < 500);
            send_beat(rnd_matrix());
        end
        calm = 1'b0;
        s_tvalid <= 1'b0;

        while (quat_q.size() != 0) @(posedge aclk);
        drain = 0;
        while (drain < DRAIN_CYC) begin
            @(posedge aclk);
            drain++;
        end
        if (errors == 0) $display("rotation_matrix_to_quaternion regression: pass");
        else $display("rotation_matrix_to_quaternion regression: fail");
        $finish;
    end
endmodule
